// ===== rtl/set_assoc_lru_cache_model_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the LRU cache model
// Short forms of the concurrent checks used by the top level. Each expects
// clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH

// Same-cycle implication
`define SALC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("salc: same-cycle check failed");

// Next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("salc: next-cycle check failed");

`endif

// ===== rtl/salc_pkg.sv =====
// ---------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and helpers of the set-associative LRU cache model.
// ---------------------------------------------------------------------------
package salc_pkg;

	// Default geometry
	localparam int WAYS_DEF         = 8;
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int ADDR_BITS_DEF    = 48;

	// Fixed field widths
	localparam int KIND_W      = 2;
	localparam int OUTCOME_W   = 2;
	localparam int SET_PORT_W  = 6;
	localparam int WAY_PORT_W  = 3;
	localparam int CNT_W       = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	// Configuration register widths and reset values
	localparam int SET_BITS_CFG_W = 3;
	localparam int OFFSET_CFG_W   = 6;
	localparam int WAYS_CFG_W     = 4;
	localparam logic [SET_BITS_CFG_W-1:0] SET_BITS_RESET = 3'd0;
	localparam logic [OFFSET_CFG_W-1:0]   OFFSET_RESET   = 6'd4;
	localparam logic [WAYS_CFG_W-1:0]     WAYS_RESET     = 4'd8;

	// Clamped set-bit count (at most 7) and total shift (at most 70)
	localparam int SBITS_W = 4;
	localparam int SHIFT_W = 7;

	// Access kinds
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SET_INDEX_BITS = 2'd0,
		CFG_OFFSET_BITS    = 2'd1,
		CFG_WAYS_IN_USE    = 2'd2
	} cfg_index_t;

	// Outcome of one access
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// Status of one lookup, handed from the lookup logic to the top level
	typedef struct packed {
		outcome_t               outcome;
		logic [WAY_PORT_W-1:0]  way;
	} lookup_res_t;

	// Saturating increment of a running total
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ===== rtl/salc_row_mem.sv =====
// ---------------------------------------------------------------------------
// salc_row_mem
// Simple dual-port memory, one row per set, one write and one registered
// read per cycle.
// ---------------------------------------------------------------------------
module salc_row_mem #(
	parameter  int DEPTH = 64,
	parameter  int ROW_W = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [ROW_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0] mem [DEPTH];

	// Write one row, read one row; read data holds until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/salc_lookup.sv =====
// ---------------------------------------------------------------------------
// salc_lookup
// Tag match, fill and victim choice on one set row, and the updated row
// with its recency ranks.
// ---------------------------------------------------------------------------
module salc_lookup #(
	parameter  int WAYS      = salc_pkg::WAYS_DEF,
	parameter  int ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int NW_W      = $clog2(WAYS + 1)
) (
	input  logic [WAYS-1:0]                row_valid,
	input  logic [WAYS-1:0][ADDR_BITS-1:0] row_tag,
	input  logic [WAYS-1:0][WAY_W-1:0]     row_rank,
	input  logic [ADDR_BITS-1:0]           tag,
	input  logic [NW_W-1:0]                nways,
	output logic [WAYS-1:0]                new_valid,
	output logic [WAYS-1:0][ADDR_BITS-1:0] new_tag,
	output logic [WAYS-1:0][WAY_W-1:0]     new_rank,
	output salc_pkg::lookup_res_t          res
);

	logic [WAYS-1:0] in_range;
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] empty;
	logic [WAYS-1:0] victim_hot;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] fill_way;
	logic [WAY_W-1:0] victim_way;

	// Per-way flags and a pairwise compare for the least recent way in range
	always_comb begin
		logic win;
		for (int i = 0; i < WAYS; i++) begin
			in_range[i] = (i < int'(nways));
			match[i]    = in_range[i] && row_valid[i] && (row_tag[i] == tag);
			empty[i]    = in_range[i] && !row_valid[i];
		end
		for (int i = 0; i < WAYS; i++) begin
			win = in_range[i];
			for (int j = 0; j < WAYS; j++) begin
				if (in_range[j] && j < i) begin
					win = win && (row_rank[j] <= row_rank[i]);
				end else if (in_range[j] && j > i) begin
					win = win && (row_rank[j] < row_rank[i]);
				end
			end
			victim_hot[i] = win;
		end
	end

	// Lowest-numbered way of each kind
	always_comb begin
		hit_way    = '0;
		fill_way   = '0;
		victim_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (empty[i]) begin
				fill_way = WAY_W'(i);
			end
			if (victim_hot[i]) begin
				victim_way = WAY_W'(i);
			end
		end
	end

	// Choose the way, age the others and install the line as most recent
	always_comb begin
		logic [WAY_W-1:0] sel;
		logic             was_valid;
		logic [WAY_W-1:0] old_rank;
		salc_pkg::outcome_t oc;
		if (|match) begin
			sel       = hit_way;
			was_valid = 1'b1;
			oc        = salc_pkg::OUT_HIT;
		end else if (|empty) begin
			sel       = fill_way;
			was_valid = 1'b0;
			oc        = salc_pkg::OUT_FILL;
		end else begin
			sel       = victim_way;
			was_valid = 1'b1;
			oc        = salc_pkg::OUT_EVICT;
		end
		old_rank = row_rank[sel];
		for (int i = 0; i < WAYS; i++) begin
			new_rank[i] = row_rank[i];
			if (WAY_W'(i) != sel && row_valid[i] && (!was_valid || row_rank[i] < old_rank)) begin
				new_rank[i] = row_rank[i] + 1'b1;
			end
		end
		new_rank[sel]  = '0;
		new_valid      = row_valid;
		new_valid[sel] = 1'b1;
		new_tag        = row_tag;
		new_tag[sel]   = tag;
		res.outcome    = oc;
		res.way        = salc_pkg::WAY_PORT_W'(sel);
	end

endmodule

// ===== rtl/set_assoc_lru_cache_model_top.sv =====
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// Tag-only set-associative cache with true LRU replacement and hit, miss
// and eviction totals.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one item: kind and address.
//    A modify gives two result items, the second flagged by last and always
//    a hit; any other kind gives one.
//  - Output channel (out_valid/out_ready) carries outcome, set, way and the
//    running totals after that access.
//  - Each set is one row of a synchronous memory: the row is read at the
//    edge that accepts the item, and the lookup and write-back of the row
//    follow once the output register is free; the result is registered
//    with the write-back. A new item is taken only after the last access
//    of the previous one; the second access of a modify works on the
//    forwarded row.
//  - A new item is accepted while a result waits in the output register;
//    while the receiver stalls, the lookup of that item holds.
//  - After reset the block clears the valid bits of every set, one row a
//    cycle (2**MAX_SET_BITS rows, 64 by default) and takes no item then.
//    Configuration writes take effect at the next edge; make them only
//    while no item is in flight.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_top_assert.svh"

module set_assoc_lru_cache_model_top #(
	parameter  int WAYS         = salc_pkg::WAYS_DEF,
	parameter  int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter  int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [salc_pkg::KIND_W-1:0]        kind,
	input  logic [ADDR_BITS-1:0]               address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [salc_pkg::OUTCOME_W-1:0]     outcome,
	output logic [salc_pkg::SET_PORT_W-1:0]    set_index,
	output logic [salc_pkg::WAY_PORT_W-1:0]    way,
	output logic                               last,
	output logic [salc_pkg::CNT_W-1:0]         hit_count,
	output logic [salc_pkg::CNT_W-1:0]         miss_count,
	output logic [salc_pkg::CNT_W-1:0]         eviction_count
);

	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W     = $clog2(WAYS + 1);
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int ROW_W    = WAYS * (1 + ADDR_BITS + WAY_W);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_EXEC2
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [salc_pkg::SET_BITS_CFG_W-1:0] set_bits_q;
	logic [salc_pkg::OFFSET_CFG_W-1:0]   offset_q;
	logic [salc_pkg::WAYS_CFG_W-1:0]     ways_q;

	// Item and pipeline registers
	logic [SET_W-1:0]     clr_q;
	logic [SET_W-1:0]     set_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic                 modify_q;
	logic [ROW_W-1:0]     fwd_row_q;

	// Output registers and totals
	logic                               out_valid_q;
	logic [salc_pkg::OUTCOME_W-1:0]     outcome_q;
	logic [salc_pkg::SET_PORT_W-1:0]    out_set_q;
	logic [salc_pkg::WAY_PORT_W-1:0]    out_way_q;
	logic                               out_last_q;
	logic [salc_pkg::CNT_W-1:0]         hits_q;
	logic [salc_pkg::CNT_W-1:0]         misses_q;
	logic [salc_pkg::CNT_W-1:0]         evicts_q;

	logic [salc_pkg::SBITS_W-1:0] sbits;
	logic [salc_pkg::SHIFT_W-1:0] tag_shift;
	logic [ADDR_BITS-1:0]         in_tag;
	logic [ADDR_BITS-1:0]         set_full;
	logic [SET_W:0]               set_mask;
	logic [SET_W-1:0]             in_set;
	logic [NW_W-1:0]              nways;

	logic                 accept;
	logic                 exec_fire;
	logic                 res_last;
	logic                 mem_wr_en;
	logic [SET_W-1:0]     mem_wr_addr;
	logic [ROW_W-1:0]     mem_wr_data;
	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     cur_row;
	logic [ROW_W-1:0]     new_row;

	logic [WAYS-1:0]                cur_valid;
	logic [WAYS-1:0][ADDR_BITS-1:0] cur_tag;
	logic [WAYS-1:0][WAY_W-1:0]     cur_rank;
	logic [WAYS-1:0]                new_valid;
	logic [WAYS-1:0][ADDR_BITS-1:0] new_tag;
	logic [WAYS-1:0][WAY_W-1:0]     new_rank;
	salc_pkg::lookup_res_t          lk_res;

	// Clamp the geometry and split the incoming address
	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			sbits = salc_pkg::SBITS_W'(MAX_SET_BITS);
		end else begin
			sbits = salc_pkg::SBITS_W'(set_bits_q);
		end
		if (ways_q == '0) begin
			nways = NW_W'(1);
		end else if (int'(ways_q) > WAYS) begin
			nways = NW_W'(WAYS);
		end else begin
			nways = NW_W'(ways_q);
		end
		tag_shift = salc_pkg::SHIFT_W'(sbits) + salc_pkg::SHIFT_W'(offset_q);
		in_tag    = address >> tag_shift;
		set_full  = address >> offset_q;
		set_mask  = ((SET_W + 1)'(1) << sbits) - 1'b1;
		in_set    = set_full[SET_W-1:0] & set_mask[SET_W-1:0];
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign exec_fire = (state_q == ST_EXEC || state_q == ST_EXEC2) &&
		(!out_valid_q || out_ready);
	assign res_last  = !(state_q == ST_EXEC && modify_q);

	// Memory port selection: clearing pass or write-back of the updated row
	assign mem_wr_en   = (state_q == ST_CLEAR) || exec_fire;
	assign mem_wr_addr = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign mem_wr_data = (state_q == ST_CLEAR) ? '0 : new_row;

	salc_row_mem #(
		.DEPTH (NUM_SETS),
		.ROW_W (ROW_W)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (accept),
		.rd_addr (in_set),
		.rd_data (rd_row)
	);

	// Second access of a modify works on the row just written
	assign cur_row = (state_q == ST_EXEC2) ? fwd_row_q : rd_row;
	assign {cur_valid, cur_tag, cur_rank} = cur_row;
	assign new_row = {new_valid, new_tag, new_rank};

	salc_lookup #(
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_lookup (
		.row_valid (cur_valid),
		.row_tag   (cur_tag),
		.row_rank  (cur_rank),
		.tag       (tag_q),
		.nways     (nways),
		.new_valid (new_valid),
		.new_tag   (new_tag),
		.new_rank  (new_rank),
		.res       (lk_res)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= salc_pkg::SET_BITS_RESET;
			offset_q   <= salc_pkg::OFFSET_RESET;
			ways_q     <= salc_pkg::WAYS_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				salc_pkg::CFG_SET_INDEX_BITS: begin
					set_bits_q <= cfg_data[salc_pkg::SET_BITS_CFG_W-1:0];
				end
				salc_pkg::CFG_OFFSET_BITS: begin
					offset_q <= cfg_data[salc_pkg::OFFSET_CFG_W-1:0];
				end
				salc_pkg::CFG_WAYS_IN_USE: begin
					ways_q <= cfg_data[salc_pkg::WAYS_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: clearing pass, idle, first and second access; totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
		end else begin
			if (exec_fire) begin
				out_valid_q <= 1'b1;
				if (lk_res.outcome == salc_pkg::OUT_HIT) begin
					hits_q <= salc_pkg::sat_inc(hits_q);
				end else begin
					misses_q <= salc_pkg::sat_inc(misses_q);
				end
				if (lk_res.outcome == salc_pkg::OUT_EVICT) begin
					evicts_q <= salc_pkg::sat_inc(evicts_q);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= modify_q ? ST_EXEC2 : ST_IDLE;
					end
				end
				ST_EXEC2: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the item on acceptance and the result on each access
	always_ff @(posedge clk) begin
		if (accept) begin
			set_q    <= in_set;
			tag_q    <= in_tag;
			modify_q <= (kind == salc_pkg::KIND_MODIFY);
		end
		if (exec_fire) begin
			fwd_row_q  <= new_row;
			outcome_q  <= lk_res.outcome;
			out_set_q  <= salc_pkg::SET_PORT_W'(set_q);
			out_way_q  <= lk_res.way;
			out_last_q <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign set_index      = out_set_q;
	assign way            = out_way_q;
	assign last           = out_last_q;
	assign hit_count      = hits_q;
	assign miss_count     = misses_q;
	assign eviction_count = evicts_q;

	// Checks
	`SALC_ASSERT_NEXT(a_accept_to_exec, accept, state_q == ST_EXEC)
	`SALC_ASSERT_SAME(a_result_from_exec, $rose(out_valid_q), $past(exec_fire))
	`SALC_ASSERT_SAME(a_second_access_hits, exec_fire && state_q == ST_EXEC2, lk_res.outcome == salc_pkg::OUT_HIT)
	`SALC_ASSERT_NEXT(a_totals_hold, !exec_fire, $stable(hits_q) && $stable(misses_q) && $stable(evicts_q))
	`SALC_ASSERT_NEXT(a_modify_continues, exec_fire && !res_last, state_q == ST_EXEC2)

endmodule

// ===== tb/sv/lru_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache access checker
// Watches the configuration port and both item channels of the cache model,
// predicts every access result from its own copy of the tag store, ranks and
// totals, and compares each delivered result field by field in order.
// ----------------------------------------------------------------------------
module lru_access_checker
	import salc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [KIND_W-1:0]         kind,
	input  logic [ADDR_BITS_DEF-1:0]  address,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [OUTCOME_W-1:0]      outcome,
	input  logic [SET_PORT_W-1:0]     set_index,
	input  logic [WAY_PORT_W-1:0]     way,
	input  logic                      last,
	input  logic [CNT_W-1:0]          hit_count,
	input  logic [CNT_W-1:0]          miss_count,
	input  logic [CNT_W-1:0]          eviction_count,
	output int                        mismatch_total,
	output int                        expected_left
);

	localparam int N_WAYS = WAYS_DEF;
	localparam int N_SETS = 1 << MAX_SET_BITS_DEF;

	typedef struct {
		outcome_t               outcome;
		logic [SET_PORT_W-1:0]  set_index;
		logic [WAY_PORT_W-1:0]  way;
		logic                   last;
		logic [CNT_W-1:0]       hits;
		logic [CNT_W-1:0]       misses;
		logic [CNT_W-1:0]       evictions;
	} access_result_t;

	// Shadow configuration
	logic [SET_BITS_CFG_W-1:0] set_bits_reg;
	logic [OFFSET_CFG_W-1:0]   offset_reg;
	logic [WAYS_CFG_W-1:0]     ways_reg;

	// Shadow tag store and totals
	logic        line_valid_q [N_SETS][N_WAYS];
	logic [63:0] line_tag_q   [N_SETS][N_WAYS];
	logic [7:0]  line_rank_q  [N_SETS][N_WAYS];
	logic [CNT_W-1:0] hits_total, misses_total, evictions_total;

	access_result_t result_q[$];
	int bad_fields;

	function automatic logic [CNT_W-1:0] bump_total(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Make a line the most recent; valid lines that were more recent age by one (all valid lines on a fill)
	function automatic void promote_line(input int set, input int w, input logic was_valid);
		logic [7:0] old_rank;
		int i;
		old_rank = line_rank_q[set][w];
		for (i = 0; i < N_WAYS; i++) begin
			if (i != w && line_valid_q[set][i] &&
					(!was_valid || line_rank_q[set][i] < old_rank))
				line_rank_q[set][i] = line_rank_q[set][i] + 8'd1;
		end
		line_rank_q[set][w] = 8'd0;
	endfunction

	// One cache access: search, fill or evict, update ranks and totals
	function automatic access_result_t lookup_access(input logic [ADDR_BITS_DEF-1:0] addr,
			input logic is_last);
		access_result_t r;
		int sbits, nways, sh, set, w, i;
		logic [63:0] a, tag;
		logic found;
		logic [7:0] best;
		sbits = (set_bits_reg > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(set_bits_reg);
		nways = (ways_reg == 0) ? 1 : ((ways_reg > N_WAYS) ? N_WAYS : int'(ways_reg));
		sh = sbits + offset_reg;
		a = 64'(addr);
		tag = (sh >= 64) ? 64'd0 : (a >> sh);
		set = int'((a >> offset_reg) & ((64'd1 << sbits) - 64'd1));
		found = 1'b0;
		w = 0;
		for (i = 0; i < nways && !found; i++) begin
			if (line_valid_q[set][i] && line_tag_q[set][i] == tag) begin
				found = 1'b1;
				w = i;
			end
		end
		r.outcome = OUT_HIT;
		if (found) begin
			hits_total = bump_total(hits_total);
			promote_line(set, w, 1'b1);
		end else begin
			misses_total = bump_total(misses_total);
			for (i = 0; i < nways && !found; i++) begin
				if (!line_valid_q[set][i]) begin
					found = 1'b1;
					w = i;
				end
			end
			if (found) begin
				r.outcome = OUT_FILL;
				promote_line(set, w, 1'b0);
				line_valid_q[set][w] = 1'b1;
			end else begin
				// victim is the oldest rank, the highest way on a tie
				r.outcome = OUT_EVICT;
				evictions_total = bump_total(evictions_total);
				best = 8'd0;
				for (i = 0; i < nways; i++) begin
					if (line_rank_q[set][i] >= best) begin
						best = line_rank_q[set][i];
						w = i;
					end
				end
				promote_line(set, w, 1'b1);
			end
			line_tag_q[set][w] = tag;
		end
		r.set_index = set[SET_PORT_W-1:0];
		r.way       = w[WAY_PORT_W-1:0];
		r.last      = is_last;
		r.hits      = hits_total;
		r.misses    = misses_total;
		r.evictions = evictions_total;
		return r;
	endfunction

	// Track configuration, predict accepted items, compare delivered results
	always @(posedge clk or negedge arst_n) begin : track
		access_result_t want;
		int s, w;
		if (!arst_n) begin
			set_bits_reg = SET_BITS_RESET;
			offset_reg = OFFSET_RESET;
			ways_reg = WAYS_RESET;
			for (s = 0; s < N_SETS; s++) begin
				for (w = 0; w < N_WAYS; w++) begin
					line_valid_q[s][w] = 1'b0;
					line_tag_q[s][w] = 64'd0;
					line_rank_q[s][w] = 8'd0;
				end
			end
			hits_total = '0;
			misses_total = '0;
			evictions_total = '0;
			result_q.delete();
			bad_fields = 0;
			expected_left <= 0;
			mismatch_total <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_SET_INDEX_BITS: set_bits_reg = cfg_data[SET_BITS_CFG_W-1:0];
					CFG_OFFSET_BITS:    offset_reg = cfg_data[OFFSET_CFG_W-1:0];
					CFG_WAYS_IN_USE:    ways_reg = cfg_data[WAYS_CFG_W-1:0];
					default: ;
				endcase
			end

			// a modify makes two accesses, only the second flagged last
			if (in_valid && in_ready) begin
				if (kind == KIND_MODIFY) begin
					result_q.push_back(lookup_access(address, 1'b0));
					result_q.push_back(lookup_access(address, 1'b1));
				end else begin
					result_q.push_back(lookup_access(address, 1'b1));
				end
			end

			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result item: outcome %0d set %0d way %0d",
						outcome, set_index, way);
					bad_fields++;
				end else begin
					want = result_q.pop_front();
					if (outcome !== want.outcome) begin
						$error("outcome: expected %0d, actual %0d", want.outcome, outcome);
						bad_fields++;
					end
					if (set_index !== want.set_index) begin
						$error("set_index: expected %0d, actual %0d", want.set_index, set_index);
						bad_fields++;
					end
					if (way !== want.way) begin
						$error("way: expected %0d, actual %0d", want.way, way);
						bad_fields++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						bad_fields++;
					end
					if (hit_count !== want.hits) begin
						$error("hit_count: expected %0d, actual %0d", want.hits, hit_count);
						bad_fields++;
					end
					if (miss_count !== want.misses) begin
						$error("miss_count: expected %0d, actual %0d", want.misses, miss_count);
						bad_fields++;
					end
					if (eviction_count !== want.evictions) begin
						$error("eviction_count: expected %0d, actual %0d",
							want.evictions, eviction_count);
						bad_fields++;
					end
				end
			end

			expected_left <= result_q.size();
			mismatch_total <= bad_fields;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache model testbench
// Drives load, store, modify and unused-kind items into the cache model
// under a range of geometries, with random gaps on the input side and random
// stalls on the output side; the checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
	import salc_pkg::*;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 80;
	localparam int SETTLE_TICKS = 4;
	localparam int RUN_LIMIT_NS = 20_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write_en;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [KIND_W-1:0]         kind;
	logic [ADDR_BITS_DEF-1:0]  address;
	logic                      out_valid;
	logic                      out_ready;
	logic [OUTCOME_W-1:0]      outcome;
	logic [SET_PORT_W-1:0]     set_index;
	logic [WAY_PORT_W-1:0]     way;
	logic                      last;
	logic [CNT_W-1:0]          hit_count;
	logic [CNT_W-1:0]          miss_count;
	logic [CNT_W-1:0]          eviction_count;

	int mismatch_total;
	int expected_left;

	// Current geometry, used to aim addresses at a few sets and tags
	int cur_set_bits;
	int cur_offset;
	int cur_ways;
	bit gapless;

	always #5 clk = ~clk;

	set_assoc_lru_cache_model_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.address        (address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.set_index      (set_index),
		.way            (way),
		.last           (last),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.eviction_count (eviction_count)
	);

	lru_access_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.address        (address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.set_index      (set_index),
		.way            (way),
		.last           (last),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.eviction_count (eviction_count),
		.mismatch_total (mismatch_total),
		.expected_left  (expected_left)
	);

	// Hard stop in case the block hangs
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	// Receiver: bursts of ready with short stalls, now and then long ones
	initial begin : receiver
		int burst, stall, r;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			out_ready <= 1'b1;
			repeat (burst) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 70)
				stall = $urandom_range(1, 3);
			else if (r < 95)
				stall = $urandom_range(4, 10);
			else
				stall = $urandom_range(20, 60);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (gapless || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return KIND_LOAD;
		if (r < 65)
			return KIND_STORE;
		if (r < 95)
			return KIND_MODIFY;
		return KIND_UNUSED;
	endfunction

	// Mostly addresses built from a small pool of tags and sets, some fully random
	function automatic logic [ADDR_BITS_DEF-1:0] pick_address();
		logic [63:0] t, s, o, a;
		int sbits, span;
		sbits = (cur_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set_bits;
		span = (cur_ways == 0) ? 1 : ((cur_ways > WAYS_DEF) ? WAYS_DEF : cur_ways);
		if ($urandom_range(0, 4) == 0) begin
			a = {$urandom(), $urandom()};
		end else begin
			t = $urandom_range(0, span + 2);
			s = $urandom_range(0, 3) & ((64'd1 << sbits) - 64'd1);
			o = {$urandom(), $urandom()} & ((64'd1 << cur_offset) - 64'd1);
			a = (t << (sbits + cur_offset)) | (s << cur_offset) | o;
		end
		return a[ADDR_BITS_DEF-1:0];
	endfunction

	// Present one item, hold it until accepted, then idle for a random gap
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_BITS_DEF-1:0] a);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		do @(posedge clk); while (!in_ready);
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the sender until every predicted result has been delivered
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges
	task automatic set_config(input int sb, input int off, input int nw);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_SET_INDEX_BITS;
		cfg_data <= CFG_DATA_W'(sb);
		@(posedge clk);
		cfg_index <= CFG_OFFSET_BITS;
		cfg_data <= CFG_DATA_W'(off);
		@(posedge clk);
		cfg_index <= CFG_WAYS_IN_USE;
		cfg_data <= CFG_DATA_W'(nw);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_set_bits = sb;
		cur_offset = off;
		cur_ways = nw;
	endtask

	initial begin : stimulus
		int p, n, sb, off, nw;
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= CFG_SET_INDEX_BITS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_LOAD;
		address <= '0;
		gapless = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Single set: fill every way, hit, evict, unused kind, modify
		set_config(0, 4, 8);
		send_item(KIND_LOAD, 48'h0);
		send_item(KIND_LOAD, 48'h8);
		send_item(KIND_STORE, 48'hFFFF_FFFF_FFFF);
		send_item(KIND_UNUSED, 48'h10);
		send_item(KIND_MODIFY, 48'h20);
		send_item(KIND_LOAD, 48'h30);
		send_item(KIND_LOAD, 48'h40);
		send_item(KIND_STORE, 48'h50);
		send_item(KIND_LOAD, 48'h60);
		send_item(KIND_LOAD, 48'h70);
		send_item(KIND_MODIFY, 48'h80);
		wait_drained();

		// Oversized set bits; build a duplicate tag by shrinking the ways in use
		set_config(7, 0, 2);
		send_item(KIND_LOAD, 48'h0);
		send_item(KIND_LOAD, 48'h40);
		wait_drained();
		set_config(7, 0, 0);
		send_item(KIND_LOAD, 48'h0);
		send_item(KIND_LOAD, 48'h40);
		wait_drained();
		set_config(7, 0, 2);
		send_item(KIND_LOAD, 48'h40);
		send_item(KIND_STORE, 48'h80);
		wait_drained();

		// Wide offset: tag and set collapse to zero; ways above the maximum
		set_config(6, 63, 15);
		send_item(KIND_LOAD, 48'hFFFF_FFFF_FFFF);
		send_item(KIND_MODIFY, 48'h1234_5678_9ABC);
		wait_drained();
		set_config(3, 60, 8);
		send_item(KIND_LOAD, 48'h8000_0000_0000);
		send_item(KIND_STORE, 48'h1);
		wait_drained();

		// Random phases, the first few at fixed extremes
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin sb = 6; off = 0; nw = 8; end
				1: begin sb = 0; off = 63; nw = 1; end
				2: begin sb = 7; off = 32; nw = 15; end
				3: begin sb = 3; off = 5; nw = 0; end
				default: begin
					sb = $urandom_range(0, 7);
					case ($urandom_range(0, 3))
						0: off = 0;
						1: off = $urandom_range(0, 6);
						2: off = $urandom_range(0, 63);
						default: off = ($urandom_range(0, 1) == 0) ? 63 : 48;
					endcase
					nw = $urandom_range(0, 15);
				end
			endcase
			set_config(sb, off, nw);
			gapless = (p % 4 == 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_item(pick_kind(), pick_address());
			end
			wait_drained();
		end

		if (mismatch_total == 0 && expected_left == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_row_mem.sv
rtl/salc_lookup.sv
rtl/set_assoc_lru_cache_model_top.sv
tb/sv/lru_access_checker.sv
tb/sv/tb.sv
